FILE: hw/rtl/pctb_pkg.sv
// ----------------------------------------------------------------------------
// pctb_pkg
// Shared operation codes and sequencer states for the periodic timer bank.
// ----------------------------------------------------------------------------
package pctb_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FIRED_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_REGISTER   = 3'd1,
    OP_UNREGISTER = 3'd2,
    OP_START      = 3'd3,
    OP_STOP       = 3'd4,
    OP_STATUS     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_t;

endpackage

FILE: hw/rtl/pctb_alu.sv
// ----------------------------------------------------------------------------
// pctb_alu
// Shared time unit: one 32-bit modulo adder and one unsigned less-or-equal
// compare, reused for every slot visit and for start.
// ----------------------------------------------------------------------------
module pctb_alu
  import pctb_pkg::*;
(
  input  logic [TIME_W-1:0] add_a,
  input  logic [TIME_W-1:0] add_b,
  input  logic [TIME_W-1:0] cmp_a,
  input  logic [TIME_W-1:0] cmp_b,
  output logic [TIME_W-1:0] sum,
  output logic              le
);

  // wraps modulo 2^32
  assign sum = add_a + add_b;
  assign le  = (cmp_a <= cmp_b);

endmodule

FILE: hw/rtl/periodic_callback_timer_bank_unit.sv
// Tick: one slot visited per cycle through the single shared adder and
// comparator; the strobe is registered from the last slot visit.
// Other operations: the strobe is registered from the execute state; no new item is taken while busy.
// busy is high while a slot walk or an operation executes; results cannot be stalled.
// Synchronous active-low reset clears all slot flags; period reads zero until registered.
// ----------------------------------------------------------------------------
// periodic_callback_timer_bank_unit
// Bank of SLOTS periodic timers with register/unregister/start/stop/status commands and
// a tick that walks the slots and reports those that fired.
// ----------------------------------------------------------------------------
module periodic_callback_timer_bank_unit
  import pctb_pkg::*;
#(
  parameter int unsigned SLOTS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [TIME_W-1:0]  in_interval,
  input  logic [TIME_W-1:0]  in_now_ms,
  output logic               out_valid,
  output logic [FIRED_W-1:0] out_fired_mask,
  output logic               out_running,
  output logic               out_bad_slot
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]    op_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [TIME_W-1:0]  interval_r;
  logic [TIME_W-1:0]  now_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [FIRED_W-1:0] mask_r, mask_nxt;

  logic [SLOTS-1:0]   armed_r;
  logic [SLOTS-1:0]   running_r;
  logic [SLOTS-1:0]   pvalid_r;
  logic [TIME_W-1:0]  period_mem [SLOTS];
  logic [TIME_W-1:0]  due_mem    [SLOTS];

  logic               out_valid_r, out_valid_nxt;
  logic [FIRED_W-1:0] out_fired_mask_r, out_fired_mask_nxt;
  logic               out_running_r, out_running_nxt;
  logic               out_bad_slot_r, out_bad_slot_nxt;

  logic               accept;
  logic [EXT_W-1:0]   slot_ext;
  logic [IDX_W-1:0]   slot_idx;
  logic               slot_ok;
  logic               slot_op;
  logic [IDX_W-1:0]   addr;
  logic [TIME_W-1:0]  per_rd;
  logic [TIME_W-1:0]  due_rd;
  logic [TIME_W-1:0]  add_a;
  logic [TIME_W-1:0]  sum;
  logic               le;
  logic               fire;
  logic               last_slot;
  logic [FIRED_W-1:0] fire_bit;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);

  assign slot_ext = EXT_W'(slot_r);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign slot_ok  = (32'(slot_r) < SLOTS);
  assign slot_op  = (op_r == OP_REGISTER) || (op_r == OP_UNREGISTER) ||
                    (op_r == OP_START) || (op_r == OP_STOP) || (op_r == OP_STATUS);

  assign addr      = (state_r == ST_WALK) ? idx_r : slot_idx;
  assign per_rd    = pvalid_r[addr] ? period_mem[addr] : '0;
  assign due_rd    = due_mem[addr];
  assign add_a     = (state_r == ST_WALK) ? due_rd : now_r;
  assign last_slot = (32'(idx_r) == SLOTS - 1);

  pctb_alu u_alu (
    .add_a (add_a),
    .add_b (per_rd),
    .cmp_a (due_rd),
    .cmp_b (now_r),
    .sum   (sum),
    .le    (le)
  );

  assign fire     = (state_r == ST_WALK) && armed_r[addr] && running_r[addr] && le;
  // slots beyond the mask width fire but are not reported
  assign fire_bit = fire ? (FIRED_W'(1) << idx_r) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == OP_TICK) ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        if (last_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    idx_nxt            = idx_r;
    mask_nxt           = mask_r;
    out_valid_nxt      = 1'b0;
    out_fired_mask_nxt = out_fired_mask_r;
    out_running_nxt    = out_running_r;
    out_bad_slot_nxt   = out_bad_slot_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt  = '0;
        mask_nxt = '0;
      end
      ST_EXEC: begin
        out_valid_nxt      = 1'b1;
        out_fired_mask_nxt = '0;
        out_running_nxt    = (op_r == OP_STATUS) && slot_ok && running_r[addr];
        out_bad_slot_nxt   = slot_op && !slot_ok;
      end
      ST_WALK: begin
        mask_nxt = mask_r | fire_bit;
        idx_nxt  = idx_r + IDX_W'(1);
        if (last_slot) begin
          out_valid_nxt      = 1'b1;
          out_fired_mask_nxt = mask_r | fire_bit;
          out_running_nxt    = 1'b0;
          out_bad_slot_nxt   = 1'b0;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      mask_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      mask_r      <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_operation;
      slot_r     <= in_slot;
      interval_r <= in_interval;
      now_r      <= in_now_ms;
    end
    out_fired_mask_r <= out_fired_mask_nxt;
    out_running_r    <= out_running_nxt;
    out_bad_slot_r   <= out_bad_slot_nxt;
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= '0;
      running_r <= '0;
      pvalid_r  <= '0;
    end else if (state_r == ST_EXEC && slot_ok) begin
      case (op_r)
        OP_REGISTER: begin
          armed_r[addr]   <= 1'b1;
          running_r[addr] <= 1'b0;
          pvalid_r[addr]  <= 1'b1;
        end
        OP_UNREGISTER: begin
          armed_r[addr] <= 1'b0;
        end
        OP_START: begin
          running_r[addr] <= 1'b1;
        end
        OP_STOP: begin
          running_r[addr] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // period and due time storage
  always_ff @(posedge clk) begin
    if (fire) begin
      due_mem[addr] <= sum;
    end else if (state_r == ST_EXEC && slot_ok) begin
      case (op_r)
        OP_REGISTER: begin
          period_mem[addr] <= interval_r;
          due_mem[addr]    <= '0;
        end
        OP_START: begin
          // start while running keeps the due time
          if (!running_r[addr]) begin
            due_mem[addr] <= sum;
          end
        end
        OP_STOP: begin
          due_mem[addr] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired_mask = out_fired_mask_r;
  assign out_running    = out_running_r;
  assign out_bad_slot   = out_bad_slot_r;

endmodule
